// ----- design/capacitive_touch_detector_defines.svh -----
// Assertion macros used by the capacitive touch detector top level.
`ifndef CAPACITIVE_TOUCH_DETECTOR_DEFINES_SVH
`define CAPACITIVE_TOUCH_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk, off during reset.
`define CTD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on i_clk, off during reset.
`define CTD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CTD_ASSERT_NOW(lbl, ante, cons, msg)
`define CTD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/ctd_pkg.sv -----
// Shared types and constants for the capacitive touch detector.
package ctd_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned GUARD_W  = 16;
    localparam int unsigned SUM_W    = 19;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_FRAC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_FRAC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GUARD_MS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AUTOCAL_MS   = 2'd3;

    // Configuration reset values
    localparam logic [FRAC_W-1:0]  RST_PRESS_FRAC   = 16'd6554;
    localparam logic [FRAC_W-1:0]  RST_RELEASE_FRAC = 16'd2621;
    localparam logic [GUARD_W-1:0] RST_GUARD_MS     = 16'd800;
    localparam logic [TIME_W-1:0]  RST_AUTOCAL_MS   = 32'd60000;

    // Input item mode codes
    localparam logic MODE_INIT   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic [FRAC_W-1:0]  press_frac;
        logic [FRAC_W-1:0]  release_frac;
        logic [GUARD_W-1:0] guard_ms;
        logic [TIME_W-1:0]  autocal_ms;
    } t_cfg;

    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   now_ms;
        logic                read_ok;
    } t_item;

    typedef struct packed {
        logic                pressed;
        logic [SAMPLE_W-1:0] baseline_now;
        logic                rebaselined;
        logic                calibrated;
    } t_result;

endpackage

// ----- design/capacitive_touch_detector.sv -----
// Capacitive touch detector: input register, single-pass update, output register.
// A word is taken into the input register and its result into the output register.
// Throughput: one word per cycle while i_out_stall is low; the detector state updates
// as a word moves into the output register, and the next word sees the updated state.
// Reset (synchronous, active low) clears both stage valids, the detector state and
// loads the configuration reset values.
`include "capacitive_touch_detector_defines.svh"
module capacitive_touch_detector
    import ctd_pkg::*;
#(
    parameter int unsigned INIT_READINGS = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_mode,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic                  i_read_ok,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_pressed,
    output logic [SAMPLE_W-1:0]   o_baseline_now,
    output logic                  o_rebaselined,
    output logic                  o_calibrated
);

    t_cfg    cfg;
    t_result core_res;

    logic    r_in_vld;
    t_item   r_item;
    logic    r_out_vld;
    t_result r_res;

    logic    in_load;
    logic    out_load;

    ctd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ctd_core #(
        .INIT_READINGS (INIT_READINGS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (out_load),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    // handshake: the input stage drains whenever the output register frees up
    assign out_load   = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !out_load;
    assign in_load    = i_in_valid && !o_in_stall;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_vld <= 1'b1;
            end else if (out_load) begin
                r_in_vld <= 1'b0;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_item.mode    <= i_mode;
            r_item.sample  <= i_sample;
            r_item.now_ms  <= i_now_ms;
            r_item.read_ok <= i_read_ok;
        end
        if (out_load) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_pressed      = r_res.pressed;
    assign o_baseline_now = r_res.baseline_now;
    assign o_rebaselined  = r_res.rebaselined;
    assign o_calibrated   = r_res.calibrated;

    // checks
    `CTD_ASSERT_NOW(a_rebase_needs_cal, o_out_valid && o_rebaselined, o_calibrated, "rebaseline before calibration")
    `CTD_ASSERT_NOW(a_full_pipe_stalls, r_in_vld && r_out_vld && i_out_stall, o_in_stall, "input taken into a blocked pipe")
    `CTD_ASSERT_NXT(a_cal_sticky, o_out_valid && o_calibrated, o_calibrated, "calibrated flag dropped")

endmodule

// ----- design/ctd_cfg_regs.sv -----
// Configuration register file for the capacitive touch detector.
module ctd_cfg_regs
    import ctd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // register writes, low bits of the data word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_frac   <= RST_PRESS_FRAC;
            r_cfg.release_frac <= RST_RELEASE_FRAC;
            r_cfg.guard_ms     <= RST_GUARD_MS;
            r_cfg.autocal_ms   <= RST_AUTOCAL_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PRESS_FRAC:   r_cfg.press_frac   <= i_cfg_data[FRAC_W-1:0];
                REG_RELEASE_FRAC: r_cfg.release_frac <= i_cfg_data[FRAC_W-1:0];
                REG_GUARD_MS:     r_cfg.guard_ms     <= i_cfg_data[GUARD_W-1:0];
                REG_AUTOCAL_MS:   r_cfg.autocal_ms   <= i_cfg_data[TIME_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/ctd_core.sv -----
// Detection state and single-pass update logic for one word.
module ctd_core
    import ctd_pkg::*;
#(
    parameter int unsigned INIT_READINGS = 5
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_commit,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    // exact divide by INIT_READINGS: multiply by rounded-up reciprocal
    localparam int unsigned DivShift = SUM_W + CNT_W;
    localparam longint unsigned DivMul =
        ((64'd1 << DivShift) + INIT_READINGS - 1) / INIT_READINGS;
    localparam logic [DivShift:0] DivMulV = DivMul[DivShift:0];
    localparam int unsigned ProdW = SUM_W + DivShift + 1;
    localparam logic [CNT_W-1:0] InitCnt = INIT_READINGS[CNT_W-1:0];

    logic                r_pressed;
    logic [SAMPLE_W-1:0] r_base;
    logic [TIME_W-1:0]   r_base_time;
    logic [TIME_W-1:0]   r_since_time;
    logic [SUM_W-1:0]    r_init_sum;
    logic [CNT_W-1:0]    r_init_cnt;
    logic                r_cal;

    logic                n_pressed;
    logic [SAMPLE_W-1:0] n_base;
    logic [TIME_W-1:0]   n_base_time;
    logic [TIME_W-1:0]   n_since_time;
    logic [SUM_W-1:0]    n_init_sum;
    logic [CNT_W-1:0]    n_init_cnt;
    logic                n_cal;
    logic                n_rebased;

    logic [SUM_W-1:0]    sum_inc;
    logic [CNT_W-1:0]    cnt_inc;
    logic [ProdW-1:0]    avg_prod;
    logic [SAMPLE_W-1:0] avg;

    logic [SAMPLE_W:0]   diff;
    logic [TIME_W-1:0]   lhs;
    logic [TIME_W-1:0]   press_th;
    logic [TIME_W-1:0]   release_th;
    logic                over_press;
    logic                under_release;
    logic                st;
    logic                want;
    logic [TIME_W-1:0]   since_upd;
    logic [TIME_W-1:0]   age_base;
    logic [TIME_W-1:0]   age_state;

    // init averaging path
    assign sum_inc  = r_init_sum + {{(SUM_W-SAMPLE_W){1'b0}}, i_item.sample};
    assign cnt_inc  = r_init_cnt + 1'b1;
    assign avg_prod = {{(DivShift+1){1'b0}}, sum_inc} * {{SUM_W{1'b0}}, DivMulV};
    assign avg      = avg_prod[DivShift +: SAMPLE_W];

    // relative drop against the two thresholds, Q0.16
    assign diff       = {1'b0, r_base} - {1'b0, i_item.sample};
    assign lhs        = {diff[SAMPLE_W-1:0], {FRAC_W{1'b0}}};
    assign press_th   = {{(TIME_W-SAMPLE_W){1'b0}}, r_base} *
                        {{(TIME_W-FRAC_W){1'b0}}, i_cfg.press_frac};
    assign release_th = {{(TIME_W-SAMPLE_W){1'b0}}, r_base} *
                        {{(TIME_W-FRAC_W){1'b0}}, i_cfg.release_frac};
    // negative drop never presses and always releases
    assign over_press    = !diff[SAMPLE_W] && (lhs > press_th);
    assign under_release = diff[SAMPLE_W] || (lhs < release_th);

    // hysteresis and timers
    always_comb begin
        st   = r_pressed;
        want = 1'b0;
        if (over_press) begin
            st = 1'b1;
        end else if (under_release) begin
            st   = 1'b0;
            want = r_pressed;
        end
        since_upd = (st != r_pressed) ? i_item.now_ms : r_since_time;
        age_base  = i_item.now_ms - r_base_time;
        age_state = i_item.now_ms - since_upd;
        if ((age_base >= i_cfg.autocal_ms) && (age_state >= i_cfg.autocal_ms)) begin
            want = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_pressed    = r_pressed;
        n_base       = r_base;
        n_base_time  = r_base_time;
        n_since_time = r_since_time;
        n_init_sum   = r_init_sum;
        n_init_cnt   = r_init_cnt;
        n_cal        = r_cal;
        n_rebased    = 1'b0;
        if (i_item.read_ok) begin
            if (i_item.mode == MODE_INIT) begin
                n_init_sum = sum_inc;
                n_init_cnt = cnt_inc;
                if (cnt_inc >= InitCnt) begin
                    n_base       = avg;
                    n_base_time  = i_item.now_ms;
                    n_since_time = i_item.now_ms;
                    n_pressed    = 1'b0;
                    n_cal        = 1'b1;
                    n_init_sum   = '0;
                    n_init_cnt   = '0;
                    n_rebased    = 1'b1;
                end
            end else if (r_cal) begin
                n_pressed    = st;
                n_since_time = since_upd;
                if (want && (age_base >= {{(TIME_W-GUARD_W){1'b0}}, i_cfg.guard_ms})) begin
                    n_base      = i_item.sample;
                    n_base_time = i_item.now_ms;
                    n_rebased   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed    <= 1'b0;
            r_base       <= '0;
            r_base_time  <= '0;
            r_since_time <= '0;
            r_init_sum   <= '0;
            r_init_cnt   <= '0;
            r_cal        <= 1'b0;
        end else if (i_commit) begin
            r_pressed    <= n_pressed;
            r_base       <= n_base;
            r_base_time  <= n_base_time;
            r_since_time <= n_since_time;
            r_init_sum   <= n_init_sum;
            r_init_cnt   <= n_init_cnt;
            r_cal        <= n_cal;
        end
    end

    assign o_result.pressed      = n_pressed;
    assign o_result.baseline_now = n_base;
    assign o_result.rebaselined  = n_rebased;
    assign o_result.calibrated   = n_cal;

endmodule
